FILE: design/keyed_counter_table_core_assert.svh
// ----------------------------------------------------------------------------
// keyed_counter_table_core_assert.svh
// assertion macros for the keyed counter table core
// ----------------------------------------------------------------------------
`ifndef KEYED_COUNTER_TABLE_CORE_ASSERT_SVH
`define KEYED_COUNTER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// types, codes and defaults for the keyed counter table
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // item kinds
  localparam logic [2:0] KIND_ADOPT     = 3'd0;
  localparam logic [2:0] KIND_ADOPT_NIL = 3'd1;
  localparam logic [2:0] KIND_LOOKUP    = 3'd2;
  localparam logic [2:0] KIND_TAKE_MAX  = 3'd3;
  localparam logic [2:0] KIND_PEEK      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ORDER     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_ADOPT, S_SRCH_RD, S_SRCH_CMP, S_ACT, S_PEEK_RD, S_PEEK_OUT
  } kct_state_t;

  typedef enum logic [1:0] {RD_MID, RD_LO, RD_IDX} kct_rd_sel_t;

  typedef struct packed {
    logic        capture;
    logic        adopt_pre;
    logic        srch_init;
    logic        srch_step;
    logic        act;
    logic        peek_init;
    logic        peek_emit;
    kct_rd_sel_t rd_sel;
  } kct_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       adopt_ok;
    logic       srch_done;
    logic       out_free;
    logic       live_empty;
    logic       peek_end;
  } kct_stat_t;

endpackage

FILE: design/kct_in_if.sv
// ----------------------------------------------------------------------------
// kct_in_if
// input channel: one item word with valid/ready
// ----------------------------------------------------------------------------
interface kct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] key;
  logic [63:0] new_count;
  logic        list_last;

  modport source (output valid, kind, key, new_count, list_last, input ready);
  modport sink (input valid, kind, key, new_count, list_last, output ready);
endinterface

FILE: design/kct_out_if.sv
// ----------------------------------------------------------------------------
// kct_out_if
// result channel: one result word with valid/ready
// ----------------------------------------------------------------------------
interface kct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] entry_key;
  logic [63:0] entry_count;
  logic        entry_valid;
  logic        last;

  modport source (output valid, status, entry_key, entry_count, entry_valid, last,
                  input ready);
  modport sink (input valid, status, entry_key, entry_count, entry_valid, last,
                output ready);
endinterface

FILE: design/keyed_counter_table_core.sv
// ----------------------------------------------------------------------------
// keyed_counter_table_core
// sorted key table with 64-bit counters, adopt lists, lookup, take max and peek
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one item word (kind, key, new_count, list_last); out_ch
//   carries result words (status, entry_key, entry_count, entry_valid, last).
//   one item is worked at a time; in_ch.ready is high only while idle.
//   lookup, take max and adopt entry run a binary search over the live
//   bank, each halving step a read of the ram's registered read port and
//   a compare; a dropped adopt entry skips the search, and adopt empty and
//   unknown kinds go straight to their result word. peek reads and then
//   emits one word per entry. an adopt list fills the shadow bank; its
//   last entry swaps banks.
//   reset empties the table and closes any adopt pass; no clearing pass.
//   a stalled out_ch holds its word; the engine waits before its next word.
// ----------------------------------------------------------------------------
module keyed_counter_table_core #(
  parameter int TABLE_DEPTH = kct_pkg::TABLE_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  kct_in_if.sink  in_ch,
  kct_out_if.source out_ch
);

  kct_pkg::kct_cmd_t  cmd;
  kct_pkg::kct_stat_t stat;
  logic               in_rdy;

  assign in_ch.ready = in_rdy;

  kct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_rdy),
    .stat(stat), .cmd(cmd));

  kct_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_kind(in_ch.kind), .in_key(in_ch.key),
    .in_new_count(in_ch.new_count), .in_list_last(in_ch.list_last),
    .cmd(cmd), .stat(stat), .out_ch(out_ch));

  `include "keyed_counter_table_core_assert.svh"

  // a pending word is never overwritten
  `KCT_ASSERT_NOW(a_no_overwrite, !stat.out_free, !cmd.act && !cmd.peek_emit, "word overwritten")
  // one item in flight at a time
  `KCT_ASSERT_NEXT(a_one_item, in_ch.valid && in_rdy, !in_rdy, "second item taken")
  // peek words only come from a non-empty table
  `KCT_ASSERT_NOW(a_peek_nonempty, cmd.peek_emit, !stat.live_empty, "peek of empty table")

endmodule

FILE: design/kct_ram.sv
// ----------------------------------------------------------------------------
// kct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kct_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// controller state machine: sequences search, update and peek steps
// ----------------------------------------------------------------------------
module kct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kct_pkg::kct_stat_t stat,
  output kct_pkg::kct_cmd_t  cmd
);

  kct_pkg::kct_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = kct_pkg::RD_MID;
    in_ready   = 1'b0;
    case (state_r)
      kct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = kct_pkg::S_DECODE;
        end
      end
      kct_pkg::S_DECODE: begin
        case (stat.kind)
          kct_pkg::KIND_ADOPT: begin
            cmd.adopt_pre = 1'b1;
            state_nxt     = kct_pkg::S_ADOPT;
          end
          kct_pkg::KIND_LOOKUP, kct_pkg::KIND_TAKE_MAX: begin
            cmd.srch_init = 1'b1;
            state_nxt     = kct_pkg::S_SRCH_RD;
          end
          kct_pkg::KIND_PEEK: begin
            cmd.peek_init = 1'b1;
            state_nxt     = stat.live_empty ? kct_pkg::S_ACT : kct_pkg::S_PEEK_RD;
          end
          default: begin
            state_nxt = kct_pkg::S_ACT;
          end
        endcase
      end
      kct_pkg::S_ADOPT: begin
        if (stat.adopt_ok) begin
          cmd.srch_init = 1'b1;
          state_nxt     = kct_pkg::S_SRCH_RD;
        end else begin
          state_nxt = kct_pkg::S_ACT;
        end
      end
      kct_pkg::S_SRCH_RD: begin
        if (stat.srch_done) begin
          cmd.rd_sel = kct_pkg::RD_LO;
          state_nxt  = kct_pkg::S_ACT;
        end else begin
          state_nxt = kct_pkg::S_SRCH_CMP;
        end
      end
      kct_pkg::S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = kct_pkg::S_SRCH_RD;
      end
      kct_pkg::S_ACT: begin
        cmd.rd_sel = kct_pkg::RD_LO;
        if (stat.out_free) begin
          cmd.act   = 1'b1;
          state_nxt = kct_pkg::S_IDLE;
        end
      end
      kct_pkg::S_PEEK_RD: begin
        cmd.rd_sel = kct_pkg::RD_IDX;
        state_nxt  = kct_pkg::S_PEEK_OUT;
      end
      kct_pkg::S_PEEK_OUT: begin
        cmd.rd_sel = kct_pkg::RD_IDX;
        if (stat.out_free) begin
          cmd.peek_emit = 1'b1;
          state_nxt     = stat.peek_end ? kct_pkg::S_IDLE : kct_pkg::S_PEEK_RD;
        end
      end
      default: begin
        state_nxt = kct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/kct_dp.sv
// ----------------------------------------------------------------------------
// kct_dp
// datapath: two table banks, search bounds, adopt state and result register
// ----------------------------------------------------------------------------
module kct_dp #(
  parameter int TABLE_DEPTH = kct_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic [63:0]        in_key,
  input  logic [63:0]        in_new_count,
  input  logic               in_list_last,
  input  kct_pkg::kct_cmd_t  cmd,
  output kct_pkg::kct_stat_t stat,
  kct_out_if.source          out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

  // captured item
  logic [2:0]    kind_r;
  logic [63:0]   key_r, ncnt_r;
  logic          last_r;
  // search, peek and table state
  logic [SW-1:0] lo_r, hi_r, idx_r, live_size_r, shadow_size_r;
  logic [63:0]   prev_key_r;
  logic          open_r, bank_r;
  logic [1:0]    adopt_st_r;
  // result word
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [63:0]   out_key_r, out_count_r;
  logic          out_evalid_r, out_last_r;

  logic [SW-1:0] mid, eff_size, size_inc;
  logic [AW-1:0] raddr;
  logic [63:0]   k0_q, k1_q, c0_q, c1_q, rkey, rcnt;
  logic          found, adopt_ok, order_bad, full;
  logic          live_we, shadow_we;
  logic [63:0]   live_wcnt, shadow_wcnt;
  logic [1:0]    adopt_st_nxt;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // read address for the live bank
  always_comb begin
    case (cmd.rd_sel)
      kct_pkg::RD_LO:  raddr = lo_r[AW-1:0];
      kct_pkg::RD_IDX: raddr = idx_r[AW-1:0];
      default:         raddr = mid[AW-1:0];
    endcase
  end

  assign rkey  = bank_r ? k1_q : k0_q;
  assign rcnt  = bank_r ? c1_q : c0_q;
  assign found = (lo_r < live_size_r) && (rkey == key_r);

  // adopt entry checks
  assign eff_size  = open_r ? shadow_size_r : '0;
  assign order_bad = open_r && (shadow_size_r != '0) && (key_r <= prev_key_r);
  assign full      = (eff_size >= DEPTH_S);
  always_comb begin
    if (order_bad) begin
      adopt_st_nxt = kct_pkg::ST_ORDER;
    end else if (full) begin
      adopt_st_nxt = kct_pkg::ST_FULL;
    end else begin
      adopt_st_nxt = kct_pkg::ST_OK;
    end
  end
  assign adopt_ok = (adopt_st_r == kct_pkg::ST_OK);
  assign size_inc = shadow_size_r + SW'(adopt_ok);

  // table writes
  assign shadow_we   = cmd.act && (kind_r == kct_pkg::KIND_ADOPT) && adopt_ok;
  assign shadow_wcnt = found ? rcnt : 64'd1;
  always_comb begin
    live_we   = 1'b0;
    live_wcnt = rcnt + 64'd1;
    if (cmd.act && found) begin
      if (kind_r == kct_pkg::KIND_LOOKUP) begin
        live_we = 1'b1;
      end else if (kind_r == kct_pkg::KIND_TAKE_MAX && rcnt < ncnt_r) begin
        live_we   = 1'b1;
        live_wcnt = ncnt_r;
      end
    end
  end

  // bank 0 and bank 1 memories
  kct_ram #(.W(64), .DEPTH(TABLE_DEPTH)) u_key0 (
    .clk(clk), .we(shadow_we && bank_r), .waddr(shadow_size_r[AW-1:0]),
    .wdata(key_r), .raddr(raddr), .rdata(k0_q));
  kct_ram #(.W(64), .DEPTH(TABLE_DEPTH)) u_key1 (
    .clk(clk), .we(shadow_we && !bank_r), .waddr(shadow_size_r[AW-1:0]),
    .wdata(key_r), .raddr(raddr), .rdata(k1_q));
  kct_ram #(.W(64), .DEPTH(TABLE_DEPTH)) u_cnt0 (
    .clk(clk), .we(bank_r ? shadow_we : live_we),
    .waddr(bank_r ? shadow_size_r[AW-1:0] : lo_r[AW-1:0]),
    .wdata(bank_r ? shadow_wcnt : live_wcnt), .raddr(raddr), .rdata(c0_q));
  kct_ram #(.W(64), .DEPTH(TABLE_DEPTH)) u_cnt1 (
    .clk(clk), .we(bank_r ? live_we : shadow_we),
    .waddr(bank_r ? lo_r[AW-1:0] : shadow_size_r[AW-1:0]),
    .wdata(bank_r ? live_wcnt : shadow_wcnt), .raddr(raddr), .rdata(c1_q));

  // item capture, adopt status, search bounds and peek index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      ncnt_r <= in_new_count;
      last_r <= in_list_last;
    end
    if (cmd.adopt_pre) begin
      adopt_st_r <= adopt_st_nxt;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= live_size_r;
    end else if (cmd.srch_step) begin
      if (rkey < key_r) begin
        lo_r <= mid + SW'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.peek_init) begin
      idx_r <= '0;
    end else if (cmd.peek_emit) begin
      idx_r <= idx_r + SW'(1);
    end
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_size_r   <= '0;
      shadow_size_r <= '0;
      prev_key_r    <= '0;
      open_r        <= 1'b0;
      bank_r        <= 1'b0;
    end else begin
      if (cmd.adopt_pre) begin
        open_r        <= 1'b1;
        shadow_size_r <= eff_size;
      end
      if (cmd.act && kind_r == kct_pkg::KIND_ADOPT) begin
        if (adopt_ok) begin
          shadow_size_r <= size_inc;
          prev_key_r    <= key_r;
        end
        if (last_r) begin
          bank_r      <= !bank_r;
          live_size_r <= size_inc;
          open_r      <= 1'b0;
        end
      end
      if (cmd.act && kind_r == kct_pkg::KIND_ADOPT_NIL) begin
        live_size_r   <= '0;
        shadow_size_r <= '0;
        open_r        <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.act || cmd.peek_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peek_emit) begin
      out_status_r <= kct_pkg::ST_OK;
      out_key_r    <= rkey;
      out_count_r  <= rcnt;
      out_evalid_r <= 1'b1;
      out_last_r   <= stat.peek_end;
    end else if (cmd.act) begin
      out_status_r <= kct_pkg::ST_OK;
      out_key_r    <= '0;
      out_count_r  <= '0;
      out_evalid_r <= 1'b0;
      out_last_r   <= 1'b1;
      case (kind_r)
        kct_pkg::KIND_ADOPT: begin
          out_status_r <= adopt_st_r;
        end
        kct_pkg::KIND_LOOKUP: begin
          if (found) begin
            out_count_r <= rcnt;
          end else begin
            out_status_r <= kct_pkg::ST_NOT_FOUND;
          end
        end
        kct_pkg::KIND_TAKE_MAX: begin
          if (!found) begin
            out_status_r <= kct_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_key   = out_key_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.entry_valid = out_evalid_r;
  assign out_ch.last        = out_last_r;

  // status to the controller
  assign stat.kind       = kind_r;
  assign stat.adopt_ok   = adopt_ok;
  assign stat.srch_done  = (lo_r >= hi_r);
  assign stat.out_free   = !out_valid_r || out_ch.ready;
  assign stat.live_empty = (live_size_r == '0);
  assign stat.peek_end   = ({1'b0, idx_r} + (SW+1)'(1)) == {1'b0, live_size_r};

endmodule

FILE: tb/sv/keyed_counter_table_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_counter_table_core_test
// self-checking bench for the keyed counter table: directed adopt, lookup,
// take-max and peek cases, then random adopt lists and queries under
// sender idling and receiver stalls, scored against an in-bench table model
// ----------------------------------------------------------------------------
module keyed_counter_table_core_test;

  localparam int DEPTH        = kct_pkg::TABLE_DEPTH_DEF;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] ekey;
    logic [63:0] ecount;
    logic        evalid;
    logic        elast;
  } result_word_t;

  logic clk;
  logic rst_n;

  kct_in_if  in_ch();
  kct_out_if out_ch();

  keyed_counter_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // table model state
  logic [63:0]  live_key_tab [DEPTH];
  logic [63:0]  live_cnt_tab [DEPTH];
  logic [63:0]  shd_key_tab  [DEPTH];
  logic [63:0]  shd_cnt_tab  [DEPTH];
  int           live_n;
  int           shd_n;
  logic [63:0]  prev_adopt;
  logic         pass_open;

  result_word_t pending_results[$];
  pace_t        pace;
  int           errors;
  int           idle_cycles;

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------- model

  function automatic int locate_key(logic [63:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = live_n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (live_key_tab[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    if (lo < live_n && live_key_tab[lo] == k) return lo;
    return -1;
  endfunction

  task automatic push_result(logic [1:0] st, logic [63:0] k, logic [63:0] c,
                             logic v, logic l);
    result_word_t w;
    w.status = st;
    w.ekey   = k;
    w.ecount = c;
    w.evalid = v;
    w.elast  = l;
    pending_results.insert(pending_results.size(), w);
  endtask

  task automatic predict_item(logic [2:0] kind, logic [63:0] key,
                              logic [63:0] cnt, logic lst);
    int         pos;
    logic [1:0] st;
    st = kct_pkg::ST_OK;
    case (kind)
      kct_pkg::KIND_ADOPT: begin
        if (!pass_open) begin
          pass_open = 1'b1;
          shd_n = 0;
        end else if (shd_n > 0 && key <= prev_adopt) begin
          st = kct_pkg::ST_ORDER;
        end
        if (st == kct_pkg::ST_OK && shd_n >= DEPTH) st = kct_pkg::ST_FULL;
        if (st == kct_pkg::ST_OK) begin
          pos = locate_key(key);
          shd_key_tab[shd_n] = key;
          shd_cnt_tab[shd_n] = (pos >= 0) ? live_cnt_tab[pos] : 64'd1;
          shd_n++;
          prev_adopt = key;
        end
        // final entry swaps the shadow table in, even when dropped
        if (lst) begin
          live_key_tab = shd_key_tab;
          live_cnt_tab = shd_cnt_tab;
          live_n = shd_n;
          pass_open = 1'b0;
        end
        push_result(st, '0, '0, 1'b0, 1'b1);
      end
      kct_pkg::KIND_ADOPT_NIL: begin
        live_n = 0;
        shd_n = 0;
        pass_open = 1'b0;
        push_result(kct_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
      end
      kct_pkg::KIND_LOOKUP: begin
        pos = locate_key(key);
        if (pos < 0) begin
          push_result(kct_pkg::ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
        end else begin
          push_result(kct_pkg::ST_OK, '0, live_cnt_tab[pos], 1'b0, 1'b1);
          live_cnt_tab[pos] = live_cnt_tab[pos] + 64'd1;
        end
      end
      kct_pkg::KIND_TAKE_MAX: begin
        pos = locate_key(key);
        if (pos < 0) begin
          push_result(kct_pkg::ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
        end else begin
          if (live_cnt_tab[pos] < cnt) live_cnt_tab[pos] = cnt;
          push_result(kct_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      kct_pkg::KIND_PEEK: begin
        if (live_n == 0) push_result(kct_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
        for (int i = 0; i < live_n; i++)
          push_result(kct_pkg::ST_OK, live_key_tab[i], live_cnt_tab[i], 1'b1,
                      (i + 1 == live_n));
      end
      default: push_result(kct_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------- driving

  function automatic bit src_idle_now();
    case (pace)
      PACE_SRC_IDLE: return $urandom_range(99) < 57;
      PACE_BOTH:     return $urandom_range(99) < 17;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit snk_ready_now();
    case (pace)
      PACE_SNK_STALL: return $urandom_range(99) >= 57;
      PACE_BOTH:      return $urandom_range(99) >= 17;
      default:        return 1'b1;
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // one input word, held until accepted, then scored
  task automatic send_word(logic [2:0] kind, logic [63:0] key,
                           logic [63:0] cnt = '0, logic lst = 1'b0);
    while (src_idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.key       <= key;
    in_ch.new_count <= cnt;
    in_ch.list_last <= lst;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(kind, key, cnt, lst);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result sink stalls
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= snk_ready_now();
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result word, status", 64'(out_ch.status), '0);
        end else begin
          w = pending_results.pop_front();
          if (out_ch.status !== w.status)
            report("status", 64'(out_ch.status), 64'(w.status));
          if (out_ch.entry_key !== w.ekey) report("entry_key", out_ch.entry_key, w.ekey);
          if (out_ch.entry_count !== w.ecount)
            report("entry_count", out_ch.entry_count, w.ecount);
          if (out_ch.entry_valid !== w.evalid)
            report("entry_valid", 64'(out_ch.entry_valid), 64'(w.evalid));
          if (out_ch.last !== w.elast) report("last", 64'(out_ch.last), 64'(w.elast));
        end
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // queries on the empty table and unused kinds
  task automatic test_empty_table();
    send_word(kct_pkg::KIND_LOOKUP, rand_word());
    send_word(kct_pkg::KIND_TAKE_MAX, '1, '1);
    send_word(kct_pkg::KIND_PEEK, '0);
    for (int k = kct_pkg::KIND_PEEK + 1; k < 8; k++)
      send_word(k[2:0], rand_word(), rand_word(), 1'b1);
    settle();
  endtask

  // extreme keys, order errors, wrap of a counter at all ones
  task automatic test_adopt_extremes();
    send_word(kct_pkg::KIND_ADOPT, '0);
    send_word(kct_pkg::KIND_ADOPT, 64'h8000_0000_0000_0000);
    send_word(kct_pkg::KIND_ADOPT, 64'h8000_0000_0000_0000);
    send_word(kct_pkg::KIND_ADOPT, 64'h0000_0000_0000_0005);
    send_word(kct_pkg::KIND_ADOPT, '1, '0, 1'b1);
    send_word(kct_pkg::KIND_LOOKUP, '0);
    send_word(kct_pkg::KIND_LOOKUP, 64'h0000_0000_0000_0005);
    send_word(kct_pkg::KIND_TAKE_MAX, '1, '1);
    send_word(kct_pkg::KIND_LOOKUP, '1);
    send_word(kct_pkg::KIND_LOOKUP, '1);
    send_word(kct_pkg::KIND_TAKE_MAX, '0, 64'h0000_0000_0000_0000);
    send_word(kct_pkg::KIND_PEEK, '0);
    settle();
  endtask

  // re-adopt keeps counts; lookups during a pass; dropped final key
  task automatic test_readopt();
    send_word(kct_pkg::KIND_ADOPT, 64'h0000_0000_0000_0001);
    send_word(kct_pkg::KIND_LOOKUP, 64'h8000_0000_0000_0000);
    send_word(kct_pkg::KIND_ADOPT, 64'h8000_0000_0000_0000);
    send_word(kct_pkg::KIND_TAKE_MAX, '0, 64'h0000_0000_0000_0040);
    send_word(kct_pkg::KIND_ADOPT, 64'h0000_0000_0000_0002, '0, 1'b1);
    send_word(kct_pkg::KIND_PEEK, '0);
    send_word(kct_pkg::KIND_ADOPT, 64'h0000_0000_0000_0003);
    send_word(kct_pkg::KIND_ADOPT_NIL, '0);
    send_word(kct_pkg::KIND_PEEK, '0);
    send_word(kct_pkg::KIND_LOOKUP, 64'h0000_0000_0000_0001);
    settle();
  endtask

  // fill the shadow table past its depth
  task automatic test_full_table();
    for (int i = 0; i <= DEPTH; i++)
      send_word(kct_pkg::KIND_ADOPT, 64'(i) * 64'h0100_0000_0000_0003, '0, i == DEPTH);
    send_word(kct_pkg::KIND_PEEK, '0);
    send_word(kct_pkg::KIND_LOOKUP, 64'(DEPTH - 1) * 64'h0100_0000_0000_0003);
    settle();
  endtask

  function automatic logic [63:0] pick_key();
    if (live_n > 0 && $urandom_range(99) < 70)
      return live_key_tab[$urandom_range(live_n - 1)];
    if ($urandom_range(3) == 0) return 64'($urandom_range(300));
    return rand_word();
  endfunction

  // random adopt lists, mostly well formed, mixed with queries and noise
  task automatic test_random_traffic(int n_items);
    logic [63:0] keys[$];
    logic [63:0] c;
    int          sent;
    int          len;
    int          cut;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(99)) inside
        [0:29]: begin
          keys.delete();
          len = ($urandom_range(19) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 2)
                                          : $urandom_range(1, 8);
          for (int i = 0; i < len; i++) keys.insert(keys.size(), pick_key());
          keys.sort();
          for (int i = keys.size() - 1; i > 0; i--)
            if (keys[i] == keys[i-1]) keys.delete(i);
          // broken list now and then: swap, or stop short
          if (keys.size() > 2 && $urandom_range(7) == 0) begin
            c = keys[0];
            keys[0] = keys[1];
            keys[1] = c;
          end
          cut = ($urandom_range(9) == 0) ? $urandom_range(keys.size()) : keys.size();
          for (int i = 0; i < cut; i++) begin
            send_word(kct_pkg::KIND_ADOPT, keys[i], rand_word(), i == keys.size() - 1);
            if ($urandom_range(9) == 0) send_word(kct_pkg::KIND_LOOKUP, pick_key());
          end
          sent += cut;
        end
        [30:59]: begin
          send_word(kct_pkg::KIND_LOOKUP, pick_key(), rand_word(), 1'($urandom_range(1)));
          sent++;
        end
        [60:84]: begin
          case ($urandom_range(2))
            0: c = rand_word();
            1: c = '1;
            default: c = 64'($urandom_range(20));
          endcase
          send_word(kct_pkg::KIND_TAKE_MAX, pick_key(), c, 1'($urandom_range(1)));
          sent++;
        end
        [85:92]: begin
          send_word(kct_pkg::KIND_PEEK, rand_word(), rand_word(), 1'($urandom_range(1)));
          sent++;
        end
        [93:95]: begin
          send_word(kct_pkg::KIND_ADOPT_NIL, rand_word(), rand_word(),
                    1'($urandom_range(1)));
          sent++;
        end
        default: begin
          send_word(3'($urandom_range(kct_pkg::KIND_PEEK + 1, 7)), rand_word(),
                    rand_word(), 1'($urandom_range(1)));
          sent++;
        end
      endcase
    end
    settle();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    errors      = 0;
    idle_cycles = 0;
    live_n      = 0;
    shd_n       = 0;
    prev_adopt  = '0;
    pass_open   = 1'b0;
    pace        = PACE_FULL;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= kct_pkg::KIND_PEEK;
    in_ch.key       <= '0;
    in_ch.new_count <= '0;
    in_ch.list_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    pace = PACE_BOTH;
    test_adopt_extremes();
    pace = PACE_SNK_STALL;
    test_readopt();
    pace = PACE_FULL;
    test_full_table();
    for (int p = PACE_FULL; p <= PACE_BOTH; p++) begin
      pace = pace_t'(p);
      test_random_traffic(85);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
